// ----- rtl/xxt_pkg.sv -----
// ----------------------------------------------------------------------------
// xxt_pkg: shared types and constants of the XXTEA block cipher
// Register indexes, reset values, the round count table and the mix function.
// ----------------------------------------------------------------------------
package xxt_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned BW_W       = 7;
  localparam int unsigned ROUND_W    = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd5;

  localparam logic [WORD_W-1:0] XXT_DELTA = 32'h9e37_79b9;
  localparam logic [WORD_W-1:0] KEY0_RST  = 32'h8B10_413B;
  localparam logic [WORD_W-1:0] KEY1_RST  = 32'hE91D_FEFF;
  localparam logic [WORD_W-1:0] KEY2_RST  = 32'h3853_5333;
  localparam logic [WORD_W-1:0] KEY3_RST  = 32'h0514_AE40;
  localparam logic [BW_W-1:0]   BW_RST    = 7'd24;

  typedef logic [3:0][WORD_W-1:0] key_t;

  // 6 + 52/n for n in 2..64
  function automatic logic [ROUND_W-1:0] xxt_rounds(input logic [BW_W-1:0] n);
    logic [ROUND_W-1:0] q;
    if (n <= 7'd2)       q = 6'd26;
    else if (n == 7'd3)  q = 6'd17;
    else if (n == 7'd4)  q = 6'd13;
    else if (n == 7'd5)  q = 6'd10;
    else if (n == 7'd6)  q = 6'd8;
    else if (n == 7'd7)  q = 6'd7;
    else if (n == 7'd8)  q = 6'd6;
    else if (n <= 7'd10) q = 6'd5;
    else if (n <= 7'd13) q = 6'd4;
    else if (n <= 7'd17) q = 6'd3;
    else if (n <= 7'd26) q = 6'd2;
    else if (n <= 7'd52) q = 6'd1;
    else                 q = 6'd0;
    return q + 6'd6;
  endfunction

  // z: left neighbor, y: right neighbor, k: selected key word
  function automatic logic [WORD_W-1:0] xxt_mix(input logic [WORD_W-1:0] z,
                                                input logic [WORD_W-1:0] y,
                                                input logic [WORD_W-1:0] sum,
                                                input logic [WORD_W-1:0] k);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    b = (sum ^ y) + (k ^ z);
    return a ^ b;
  endfunction

endpackage

// ----- rtl/xxt_fifo.sv -----
// ----------------------------------------------------------------------------
// xxt_fifo: small synchronous queue
// Register-based FIFO with occupancy count; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module xxt_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [WIDTH-1:0]               data_i,
  output logic                           full_o,
  input  logic                           pop_i,
  output logic [WIDTH-1:0]               data_o,
  output logic                           empty_o,
  output logic [$clog2(DEPTH+1)-1:0]     count_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- rtl/xxt_front.sv -----
// ----------------------------------------------------------------------------
// xxt_front: input word classifier
// Counts accepted words against the block length and tags the block's last.
// ----------------------------------------------------------------------------
module xxt_front
  import xxt_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_WORDS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic [BW_W-1:0]                      block_words_i,
  output logic                                 last_o,
  output logic [$clog2(MAX_BLOCK_WORDS+1)-1:0] n_o
);

  localparam int unsigned AW = $clog2(MAX_BLOCK_WORDS);
  localparam int unsigned NW = $clog2(MAX_BLOCK_WORDS+1);
  localparam int unsigned CW = AW + 1;

  logic [AW-1:0] count_q;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] n_ext;

  // clamp length into 2..MAX_BLOCK_WORDS
  always_comb begin
    if (block_words_i < 7'd2) begin
      n_o = NW'(2);
    end else if (block_words_i > BW_W'(MAX_BLOCK_WORDS)) begin
      n_o = NW'(MAX_BLOCK_WORDS);
    end else begin
      n_o = NW'(block_words_i);
    end
  end

  assign cnt_inc = {1'b0, count_q} + 1'b1;
  assign n_ext   = CW'(n_o);
  assign last_o  = (cnt_inc >= n_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= last_o ? '0 : cnt_inc[AW-1:0];
    end
  end

endmodule

// ----- rtl/xxt_back.sv -----
// ----------------------------------------------------------------------------
// xxt_back: XXTEA round engine
// Loads queued words into the block store, runs the rounds one word update
// per cycle over a two-read-port store, then streams the block out.
// ----------------------------------------------------------------------------
module xxt_back
  import xxt_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_WORDS = 64,
  parameter int unsigned OUT_DEPTH       = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_empty_i,
  input  logic [WORD_W-1:0]                    q_word_i,
  input  logic                                 q_last_i,
  input  logic [$clog2(MAX_BLOCK_WORDS+1)-1:0] q_n_i,
  output logic                                 q_pop_o,
  input  key_t                                 key_i,
  input  logic                                 decrypt_i,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]       res_count_i,
  output logic                                 res_push_o,
  output logic [WORD_W-1:0]                    res_word_o,
  output logic                                 res_last_o
);

  localparam int unsigned AW  = $clog2(MAX_BLOCK_WORDS);
  localparam int unsigned NW  = $clog2(MAX_BLOCK_WORDS+1);
  localparam int unsigned OCW = $clog2(OUT_DEPTH+1) + 1;

  typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_EMIT} state_e;

  state_e             state_q;
  logic [AW-1:0]      wr_ptr_q, p_q, s2_p_q, em_ptr_q;
  logic [NW-1:0]      n_q;
  logic               dec_q, prime_q, s2_v_q, em_v_q, em_last_q;
  logic [ROUND_W-1:0] rounds_q;
  logic [WORD_W-1:0]  sum_q, s2_sum_q, nreg_q;

  logic [WORD_W-1:0]  mem [MAX_BLOCK_WORDS];
  logic [WORD_W-1:0]  rd_a_q, rd_b_q;
  logic [AW-1:0]      ra_a, ra_b, wa;
  logic               we;
  logic [WORD_W-1:0]  wd;

  logic [AW-1:0]      nm1, q_nm1;
  logic               load_pop, end_round, emit_go;
  logic [ROUND_W-1:0] rnd;
  logic [WORD_W-1:0]  dec_sum;
  logic [1:0]         kidx;
  logic [WORD_W-1:0]  z, y, mix_w, new_word;
  logic [OCW-1:0]     occ;

  assign nm1       = AW'(n_q - 1'b1);
  assign q_nm1     = AW'(q_n_i - 1'b1);
  assign load_pop  = (state_q == ST_LOAD) && !q_empty_i;
  assign end_round = dec_q ? (p_q == '0) : (p_q == nm1);
  assign rnd       = xxt_rounds(BW_W'(q_n_i));
  assign dec_sum   = WORD_W'(rnd) * XXT_DELTA;

  // one beat in flight from the store read, so keep a slot for it
  assign occ     = OCW'(res_count_i) + OCW'(em_v_q);
  assign emit_go = (state_q == ST_EMIT) && (occ < OCW'(OUT_DEPTH));

  // update stage
  assign kidx     = 2'(s2_p_q) ^ s2_sum_q[3:2];
  assign z        = dec_q ? rd_b_q : nreg_q;
  assign y        = dec_q ? nreg_q : rd_b_q;
  assign mix_w    = xxt_mix(z, y, s2_sum_q, key_i[kidx]);
  assign new_word = dec_q ? (rd_a_q - mix_w) : (rd_a_q + mix_w);

  always_comb begin
    ra_a = '0;
    ra_b = '0;
    unique case (state_q)
      ST_LOAD: begin
        // prime read of the starting neighbor
        ra_b = decrypt_i ? '0 : q_nm1;
      end
      ST_RUN: begin
        ra_a = p_q;
        if (dec_q) ra_b = (p_q == '0) ? nm1 : p_q - 1'b1;
        else       ra_b = (p_q == nm1) ? '0 : p_q + 1'b1;
      end
      ST_EMIT: begin
        ra_a = em_ptr_q;
      end
      default: begin
        ra_a = '0;
      end
    endcase
  end

  assign we = s2_v_q | load_pop;
  assign wa = s2_v_q ? s2_p_q : wr_ptr_q;
  assign wd = s2_v_q ? new_word : q_word_i;

  // block store; same-address write forwards into the read register
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_a_q <= (we && wa == ra_a) ? wd : mem[ra_a];
    rd_b_q <= (we && wa == ra_b) ? wd : mem[ra_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      wr_ptr_q  <= '0;
      p_q       <= '0;
      s2_p_q    <= '0;
      em_ptr_q  <= '0;
      n_q       <= NW'(2);
      dec_q     <= 1'b0;
      prime_q   <= 1'b0;
      s2_v_q    <= 1'b0;
      em_v_q    <= 1'b0;
      em_last_q <= 1'b0;
      rounds_q  <= '0;
      sum_q     <= '0;
      s2_sum_q  <= '0;
      nreg_q    <= '0;
    end else begin
      s2_v_q <= 1'b0;
      em_v_q <= emit_go;
      if (s2_v_q)       nreg_q <= new_word;
      else if (prime_q) nreg_q <= rd_b_q;

      unique case (state_q)
        ST_LOAD: begin
          if (load_pop) begin
            if (q_last_i) begin
              wr_ptr_q <= '0;
              n_q      <= q_n_i;
              dec_q    <= decrypt_i;
              rounds_q <= rnd;
              sum_q    <= decrypt_i ? dec_sum : XXT_DELTA;
              p_q      <= decrypt_i ? q_nm1 : '0;
              prime_q  <= 1'b1;
              state_q  <= ST_RUN;
            end else begin
              wr_ptr_q <= wr_ptr_q + 1'b1;
            end
          end
        end
        ST_RUN: begin
          prime_q  <= 1'b0;
          s2_v_q   <= 1'b1;
          s2_p_q   <= p_q;
          s2_sum_q <= sum_q;
          if (end_round) begin
            p_q      <= dec_q ? nm1 : '0;
            sum_q    <= dec_q ? sum_q - XXT_DELTA : sum_q + XXT_DELTA;
            rounds_q <= rounds_q - 1'b1;
            if (rounds_q == ROUND_W'(1)) begin
              em_ptr_q <= '0;
              state_q  <= ST_EMIT;
            end
          end else begin
            p_q <= dec_q ? p_q - 1'b1 : p_q + 1'b1;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            em_last_q <= (em_ptr_q == nm1);
            if (em_ptr_q == nm1) state_q  <= ST_LOAD;
            else                 em_ptr_q <= em_ptr_q + 1'b1;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign q_pop_o    = load_pop;
  assign res_push_o = em_v_q;
  assign res_word_o = rd_a_q;
  assign res_last_o = em_last_q;

endmodule

// ----- rtl/xxtea_block_cipher.sv -----
// ----------------------------------------------------------------------------
// xxtea_block_cipher: XXTEA block encrypt/decrypt engine
// Collects a block of 32-bit words, runs the XXTEA rounds, streams it back.
// ----------------------------------------------------------------------------
// Input: one data word per beat (push/full). Words go into a small queue and
// are tagged against block_words; the beat that completes a block starts
// the cipher as it leaves the queue; direction is sampled then, key read live.
// Output: transformed words in block order (empty/pop); result_last_o marks
// the final word of the block.
// Per block of n words: the words are loaded, the rounds run at one word
// update per cycle (the block store with two read ports and one write port
// sets this), and the words are emitted; the first word passes through the
// store read register and the result queue before it reaches the result ports.
// The input queue keeps taking words of the next block until it fills while
// the rounds run. A stalled receiver fills the result queue and pauses the
// emit sequencer; nothing is dropped.
// Reset clears the control state and loads the register defaults; the block
// store is not cleared and needs no clearing pass. Config is written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module xxtea_block_cipher
  import xxt_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_WORDS = 64,
  parameter int unsigned IN_DEPTH        = 4,
  parameter int unsigned OUT_DEPTH       = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push,
  output logic                  full,
  input  logic [WORD_W-1:0]     data_word_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [WORD_W-1:0]     result_word_o,
  output logic                  result_last_o
);

  localparam int unsigned NW  = $clog2(MAX_BLOCK_WORDS+1);
  localparam int unsigned QW  = WORD_W + 1 + NW;
  localparam int unsigned RW  = WORD_W + 1;
  localparam int unsigned OCW = $clog2(OUT_DEPTH+1);

  key_t            key_q;
  logic [BW_W-1:0] bw_q;
  logic            mode_q;

  logic            in_accept;
  logic            f_last;
  logic [NW-1:0]   f_n;
  logic [QW-1:0]   q_din, q_dout;
  logic            q_empty, q_pop;
  logic [RW-1:0]   r_din, r_dout;
  logic            r_push;
  logic [OCW-1:0]  r_count;
  logic [WORD_W-1:0] r_word;
  logic            r_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= KEY0_RST;
      key_q[1] <= KEY1_RST;
      key_q[2] <= KEY2_RST;
      key_q[3] <= KEY3_RST;
      bw_q     <= BW_RST;
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY0: key_q[0] <= cfg_wdata_i;
        REG_KEY1: key_q[1] <= cfg_wdata_i;
        REG_KEY2: key_q[2] <= cfg_wdata_i;
        REG_KEY3: key_q[3] <= cfg_wdata_i;
        REG_BW:   bw_q     <= cfg_wdata_i[BW_W-1:0];
        REG_MODE: mode_q   <= cfg_wdata_i[0];
        default:  bw_q     <= bw_q;
      endcase
    end
  end

  assign in_accept = push & ~full;

  xxt_front #(
    .MAX_BLOCK_WORDS (MAX_BLOCK_WORDS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .block_words_i (bw_q),
    .last_o        (f_last),
    .n_o           (f_n)
  );

  assign q_din = {data_word_i, f_last, f_n};

  xxt_fifo #(
    .WIDTH (QW),
    .DEPTH (IN_DEPTH)
  ) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .data_i  (q_din),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_dout),
    .empty_o (q_empty),
    .count_o ()
  );

  xxt_back #(
    .MAX_BLOCK_WORDS (MAX_BLOCK_WORDS),
    .OUT_DEPTH       (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_word_i    (q_dout[QW-1 -: WORD_W]),
    .q_last_i    (q_dout[NW]),
    .q_n_i       (q_dout[NW-1:0]),
    .q_pop_o     (q_pop),
    .key_i       (key_q),
    .decrypt_i   (mode_q),
    .res_count_i (r_count),
    .res_push_o  (r_push),
    .res_word_o  (r_word),
    .res_last_o  (r_last)
  );

  assign r_din = {r_word, r_last};

  xxt_fifo #(
    .WIDTH (RW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (r_push),
    .data_i  (r_din),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (r_dout),
    .empty_o (empty),
    .count_o (r_count)
  );

  assign result_word_o = r_dout[RW-1:1];
  assign result_last_o = r_dout[0];

endmodule

// ----- sim/xxtea_block_cipher_tb.sv -----
// ----------------------------------------------------------------------------
// xxtea_block_cipher_tb: self-checking bench for the XXTEA block engine
// Streams data words through the push/full port and checks every popped word
// and its last flag against a local XXTEA model. Registers change between
// phases only, once the engine has drained.
// ----------------------------------------------------------------------------
module xxtea_block_cipher_tb;
  import xxt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned STORE_DEPTH  = 64;
  localparam int unsigned ITEM_GOAL    = 460;
  localparam int unsigned DRAIN_CYCLES = 500;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned MAX_PRINTS   = 100;

  // indexes past the register list, written to check that they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } cipher_beat_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  push        = 1'b0;
  logic                  full;
  logic [WORD_W-1:0]     data_word_i = '0;
  logic                  empty;
  logic                  pop         = 1'b0;
  logic [WORD_W-1:0]     result_word_o;
  logic                  result_last_o;

  xxtea_block_cipher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .data_word_i   (data_word_i),
    .empty         (empty),
    .pop           (pop),
    .result_word_o (result_word_o),
    .result_last_o (result_last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // register copies and block state of the local model
  logic [3:0][WORD_W-1:0] key_reg;
  logic [BW_W-1:0]        blk_len_reg;
  logic                   decrypt_reg;
  logic [WORD_W-1:0]      block_words_mem [STORE_DEPTH];
  int unsigned            fill_count;

  cipher_beat_t      cipher_out_q [$];
  logic [WORD_W-1:0] plain_backlog [$];

  int unsigned items_queued = 0;
  int unsigned items_sent   = 0;
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  logic        push_taken   = 1'b0;
  logic        pop_taken    = 1'b0;
  logic        no_idle      = 1'b0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int unsigned clamp_len(input logic [BW_W-1:0] v);
    if (v < 2) return 2;
    if (v > STORE_DEPTH) return STORE_DEPTH;
    return 32'(v);
  endfunction

  function automatic logic [WORD_W-1:0] round_term(input logic [WORD_W-1:0] z,
                                                   input logic [WORD_W-1:0] y,
                                                   input logic [WORD_W-1:0] sum,
                                                   input int unsigned       p,
                                                   input int unsigned       e);
    logic [1:0]        ksel;
    logic [WORD_W-1:0] lhs;
    logic [WORD_W-1:0] rhs;
    ksel = p[1:0] ^ e[1:0];
    lhs  = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    rhs  = (sum ^ y) + (key_reg[ksel] ^ z);
    return lhs ^ rhs;
  endfunction

  // full XXTEA pass over the first n stored words
  task automatic cipher_block(input int unsigned n);
    int unsigned       rounds;
    int unsigned       e;
    int                p;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] y;
    rounds = 6 + 52 / n;
    if (decrypt_reg) begin
      sum = rounds * XXT_DELTA;
      y   = block_words_mem[0];
      repeat (rounds) begin
        e = (sum >> 2) & 3;
        for (p = n - 1; p > 0; p--) begin
          z = block_words_mem[p - 1];
          block_words_mem[p] -= round_term(z, y, sum, p, e);
          y = block_words_mem[p];
        end
        z = block_words_mem[n - 1];
        block_words_mem[0] -= round_term(z, y, sum, 0, e);
        y = block_words_mem[0];
        sum -= XXT_DELTA;
      end
    end else begin
      sum = '0;
      z   = block_words_mem[n - 1];
      repeat (rounds) begin
        sum += XXT_DELTA;
        e = (sum >> 2) & 3;
        for (p = 0; p < n - 1; p++) begin
          y = block_words_mem[p + 1];
          block_words_mem[p] += round_term(z, y, sum, p, e);
          z = block_words_mem[p];
        end
        y = block_words_mem[0];
        block_words_mem[n - 1] += round_term(z, y, sum, n - 1, e);
        z = block_words_mem[n - 1];
      end
    end
  endtask

  // one accepted data word; a completed block queues its n cipher words
  task automatic absorb_word(input logic [WORD_W-1:0] w);
    int unsigned  n;
    cipher_beat_t beat;
    n = clamp_len(blk_len_reg);
    if (fill_count >= STORE_DEPTH) fill_count = 0;
    block_words_mem[fill_count] = w;
    fill_count++;
    if (fill_count >= n) begin
      cipher_block(n);
      for (int unsigned i = 0; i < n; i++) begin
        beat.word = block_words_mem[i];
        beat.last = (i == n - 1);
        cipher_out_q.push_back(beat);
      end
      fill_count = 0;
    end
  endtask

  task automatic check_beat(input logic [WORD_W-1:0] word, input logic last);
    cipher_beat_t exp_beat;
    if (cipher_out_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result beat word=%h last=%b", word, last));
    end else begin
      exp_beat = cipher_out_q.pop_front();
      if (word !== exp_beat.word)
        report_mismatch($sformatf("result_word %h, expected %h", word, exp_beat.word));
      if (last !== exp_beat.last)
        report_mismatch($sformatf("result_last %b, expected %b", last, exp_beat.last));
    end
  endtask

  // monitor: both handshakes sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      push_taken <= push && !full;
      pop_taken  <= pop && !empty;
      if (push && !full) begin
        items_sent++;
        absorb_word(data_word_i);
      end
      if (pop && !empty) check_beat(result_word_o, result_last_o);
    end
  end

  // input driver: random idle gap before each beat, none when no_idle is set
  always @(negedge clk_i) begin
    int unsigned wait_n;
    if (rst_ni && (!push || push_taken)) begin
      wait_n = push ? (no_idle ? 0 : $urandom_range(0, 3)) : gap_left;
      if (wait_n != 0 || plain_backlog.size() == 0) begin
        push     <= 1'b0;
        gap_left <= (wait_n != 0) ? wait_n - 1 : 0;
      end else begin
        push        <= 1'b1;
        data_word_i <= plain_backlog.pop_front();
      end
    end
  end

  // result side: random stall after each beat, none when no_idle is set
  always @(negedge clk_i) begin
    int unsigned wait_n;
    if (rst_ni && (!pop || pop_taken)) begin
      wait_n = pop ? (no_idle ? 0 : $urandom_range(0, 3)) : stall_left;
      if (wait_n != 0) begin
        pop        <= 1'b0;
        stall_left <= wait_n - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("xxtea_block_cipher verification failed");
      $finish;
    end
  end

  task automatic queue_word(input logic [WORD_W-1:0] w);
    plain_backlog.push_back(w);
    items_queued++;
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly short blocks, a few long ones and out-of-range lengths
  function automatic logic [BW_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return BW_W'($urandom_range(2, 8));
    if (r < 17) return BW_W'($urandom_range(9, 30));
    if (r == 17) return BW_W'(STORE_DEPTH);
    if (r == 18) return BW_W'($urandom_range(0, 1));
    return BW_W'($urandom_range(STORE_DEPTH + 1, 127));
  endfunction

  // registers change only at idle points, with the model updated in step
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_KEY0: key_reg[0]  = val;
      REG_KEY1: key_reg[1]  = val;
      REG_KEY2: key_reg[2]  = val;
      REG_KEY3: key_reg[3]  = val;
      REG_BW:   blk_len_reg = val[BW_W-1:0];
      REG_MODE: decrypt_reg = val[0];
      default:  ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender holds off until all words are in and every result has come out
  task automatic wait_drained();
    do @(negedge clk_i);
    while (items_sent != items_queued || cipher_out_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    logic [BW_W-1:0] len;
    int unsigned     eff;
    int unsigned     nblk;
    key_reg     = {KEY3_RST, KEY2_RST, KEY1_RST, KEY0_RST};
    blk_len_reg = BW_RST;
    decrypt_reg = 1'b0;
    fill_count  = 0;
    foreach (block_words_mem[i]) block_words_mem[i] = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // register defaults: one 24-word encrypt block
    queue_word('0);
    queue_word('1);
    queue_word(32'hAAAA_AAAA);
    queue_word(32'h5555_5555);
    repeat (20) queue_word(rand_word());
    wait_drained();

    // length 0 clamps to 2, all-zero key
    set_reg(REG_BW, 32'd0);
    for (int k = 0; k < 4; k++) set_reg(CFG_IDX_W'(REG_KEY0 + k), '0);
    queue_word('0);
    queue_word('0);
    wait_drained();

    // length 1 clamps to 2, all-ones key, decrypt
    set_reg(REG_BW, 32'd1);
    set_reg(REG_MODE, 32'd1);
    for (int k = 0; k < 4; k++) set_reg(CFG_IDX_W'(REG_KEY0 + k), '1);
    queue_word('1);
    queue_word('1);
    wait_drained();

    // length and direction cut while a block is half loaded; spare indexes ignored
    set_reg(REG_SPARE_LO, $urandom);
    set_reg(REG_SPARE_HI, $urandom);
    set_reg(REG_BW, 32'd8);
    set_reg(REG_MODE, 32'd0);
    repeat (5) queue_word(rand_word());
    wait_drained();
    set_reg(REG_BW, 32'd3);
    set_reg(REG_MODE, 32'd1);
    set_reg(REG_KEY2, $urandom);
    queue_word(rand_word());
    wait_drained();

    // random phases; a partial tail sometimes carries into the next setting
    while (items_queued < ITEM_GOAL) begin
      len = pick_len();
      set_reg(REG_BW, ($urandom & ~32'h7F) | len);
      set_reg(REG_MODE, ($urandom & ~32'h1) | $urandom_range(0, 1));
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(0, 1)) set_reg(CFG_IDX_W'(REG_KEY0 + k), rand_word());
      end
      if ($urandom_range(0, 9) == 0) begin
        set_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
      end
      no_idle = ($urandom_range(0, 3) == 0);
      eff  = clamp_len(len);
      nblk = (eff > 30) ? 1 : $urandom_range(1, 4);
      repeat (nblk * eff) queue_word(rand_word());
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, eff - 1)) queue_word(rand_word());
      wait_drained();
    end

    if (error_count == 0) begin
      $display("xxtea_block_cipher verification clean");
    end else begin
      $display("xxtea_block_cipher verification failed");
    end
    $finish;
  end

endmodule
